FILE: rtl/core/rtb_pkg.sv
// Shared types and constants for the IPv4 route table.
// Holds entry layout, command codes and sequencer states; no dependencies.
`default_nettype none

package rtb_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int DEVICE_COUNT  = 15;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;
  localparam logic [31:0] MCAST_MASK = 32'hF000_0000;
  localparam logic [31:0] MCAST_NET  = 32'hE000_0000;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [3:0]  device;
  } entry_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/ipv4_route_table.sv
// IPv4 first-match route table: command sequencer, entry compare and result register.
// Depends on rtb_pkg and the rtb_mem entry store.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ------------------------------------------
// in        input      in_valid_i / in_stall_o   kind_i address_i netmask_i gateway_i device_i
// out       output     out_valid_o / out_stall_i accepted_o found_o out_device_o next_hop_o
//
// Clear and a refused add (bad device) skip the walk. Add, delete and
// lookup walk the stored entries through the single read port of the entry
// store, one entry per cycle; a lookup or add stops at the first hit.
// Reset clears the sequencer, the entry count and the output word valid.
// A stalled output word holds; the next input word is taken once the result is registered.

module ipv4_route_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] netmask_i,
  input  wire logic [31:0] gateway_i,
  input  wire logic [3:0]  device_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic             found_o,
  output logic [3:0]       out_device_o,
  output logic [31:0]      next_hop_o
);
  import rtb_pkg::*;

  state_e state_q, state_d;

  // Item under work.
  kind_e       kind_q, kind_d;
  entry_t      item_q, item_d;

  // Table control.
  cnt_t        count_q, count_d;   // stored entries
  cnt_t        issue_q, issue_d;   // next entry to read
  cnt_t        wr_q, wr_d;         // compaction write pointer for delete
  logic        pend_q, pend_d;     // read data valid this cycle
  logic        removed_q, removed_d;

  // Working result.
  logic        res_acc_q, res_acc_d;
  logic        res_found_q, res_found_d;
  logic [3:0]  res_dev_q, res_dev_d;
  logic [31:0] res_hop_q, res_hop_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        out_acc_q, out_acc_d;
  logic        out_found_q, out_found_d;
  logic [3:0]  out_dev_q, out_dev_d;
  logic [31:0] out_hop_q, out_hop_d;

  // Entry store port.
  logic        mem_we, mem_re;
  idx_t        mem_waddr, mem_raddr;
  entry_t      mem_wdata, mem_rdata;

  logic        in_fire;
  logic        bad_dev;
  logic        is_bcast;
  logic        hit;
  logic        same;
  logic        stop;
  logic        scan_end;
  logic        out_free;

  rtb_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign bad_dev    = (device_i == 4'd0) || (int'(device_i) > DEVICE_COUNT);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Broadcast and multicast lookups count every entry as a hit, so they take the first entry.
  assign is_bcast = (kind_q == KIND_LOOKUP) &&
                    ((item_q.address == BCAST_ADDR) ||
                     ((item_q.address & MCAST_MASK) == MCAST_NET));

  // Shared compare unit on the entry just read.
  assign hit  = is_bcast || ((item_q.address & mem_rdata.netmask) == mem_rdata.address);
  assign same = (mem_rdata.address == item_q.address) &&
                (mem_rdata.netmask == item_q.netmask) &&
                (mem_rdata.gateway == item_q.gateway) &&
                (mem_rdata.device  == item_q.device);

  assign stop     = pend_q && hit && ((kind_q == KIND_ADD) || (kind_q == KIND_LOOKUP));
  assign scan_end = !pend_q && (issue_q >= count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((kind_i == KIND_CLEAR) || ((kind_i == KIND_ADD) && bad_dev)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stop || scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and table control.
  always_comb begin
    kind_d      = kind_q;
    item_d      = item_q;
    count_d     = count_q;
    issue_d     = issue_q;
    wr_d        = wr_q;
    pend_d      = 1'b0;
    removed_d   = removed_q;
    res_acc_d   = res_acc_q;
    res_found_d = res_found_q;
    res_dev_d   = res_dev_q;
    res_hop_d   = res_hop_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_q[IDX_W-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = issue_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d         = kind_e'(kind_i);
          item_d.address = address_i;
          item_d.netmask = netmask_i;
          item_d.gateway = gateway_i;
          item_d.device  = device_i;
          issue_d        = '0;
          wr_d           = '0;
          removed_d      = 1'b0;
          res_acc_d      = 1'b0;
          res_found_d    = 1'b0;
          res_dev_d      = 4'd0;
          res_hop_d      = 32'd0;
          if (kind_i == KIND_CLEAR) begin
            count_d   = '0;
            res_acc_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // Evaluate the entry read last cycle.
        if (pend_q) begin
          case (kind_q)
            KIND_LOOKUP: begin
              if (hit) begin
                res_found_d = 1'b1;
                res_dev_d   = mem_rdata.device;
                res_hop_d   = is_bcast ? 32'd0 : mem_rdata.gateway;
              end
            end
            KIND_DELETE: begin
              if (same) begin
                removed_d = 1'b1;
              end else begin
                // Close the gap: move the kept entry down to the write pointer.
                mem_we = 1'b1;
                wr_d   = wr_q + cnt_t'(1);
              end
            end
            default: ;
          endcase
        end

        // Issue the next read unless the walk has stopped.
        if (!stop && (issue_q < count_q)) begin
          mem_re  = 1'b1;
          issue_d = issue_q + cnt_t'(1);
          pend_d  = 1'b1;
        end

        if (scan_end) begin
          case (kind_q)
            KIND_ADD: begin
              // No covering route: append if there is room.
              if (count_q != cnt_t'(TABLE_ENTRIES)) begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = item_q;
                count_d   = count_q + cnt_t'(1);
                res_acc_d = 1'b1;
              end
            end
            KIND_DELETE: begin
              count_d   = wr_q;
              res_acc_d = removed_q;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_found_d = out_found_q;
    out_dev_d   = out_dev_q;
    out_hop_d   = out_hop_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_valid_d = 1'b1;
      out_acc_d   = res_acc_q;
      out_found_d = res_found_q;
      out_dev_d   = res_dev_q;
      out_hop_d   = res_hop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      removed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    item_q      <= item_d;
    res_acc_q   <= res_acc_d;
    res_found_q <= res_found_d;
    res_dev_q   <= res_dev_d;
    res_hop_q   <= res_hop_d;
    out_acc_q   <= out_acc_d;
    out_found_q <= out_found_d;
    out_dev_q   <= out_dev_d;
    out_hop_q   <= out_hop_d;
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign found_o      = out_found_q;
  assign out_device_o = out_dev_q;
  assign next_hop_o   = out_hop_q;

endmodule

`default_nettype wire

FILE: rtl/core/rtb_mem.sv
// Route entry storage: one write port, one read port with registered data.
// Depends on rtb_pkg for the entry layout and index type.
`default_nettype none

module rtb_mem (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire rtb_pkg::idx_t   waddr_i,
  input  wire rtb_pkg::entry_t wdata_i,
  input  wire logic            re_i,
  input  wire rtb_pkg::idx_t   raddr_i,
  output rtb_pkg::entry_t      rdata_o
);
  import rtb_pkg::*;

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
